@@ hdl/vfq_pkg.sv @@
// Shared types, codes and defaults for the virtual-time fair queue scheduler.
`default_nettype none
package vfq_pkg;

  localparam int NUM_FLOWS_D  = 16;
  localparam int TIME_WIDTH_D = 32;
  localparam int LEN_WIDTH_D  = 16;

  localparam logic [1:0] FN_SUBMIT  = 2'd0;
  localparam logic [1:0] FN_DONE    = 2'd1;
  localparam logic [1:0] FN_RELEASE = 2'd2;
  localparam logic [1:0] FN_JOB     = 2'd3;

  localparam logic CFG_MAX_VT = 1'b0;
  localparam logic CFG_CANCEL = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  flow_id;
    logic [15:0] packet_length;
  } in_t;

  typedef struct packed {
    logic        send_valid;
    logic [3:0]  send_flow;
    logic [15:0] send_length;
    logic        done_valid;
    logic [3:0]  done_flow;
    logic        cancel_valid;
    logic        status;
  } out_t;

  typedef struct packed {
    logic latch;
    logic decide;
    logic clr_cnt;
    logic scan_en;
    logic apply;
    logic reb_en;
    logic launch;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic illegal;
    logic is_release;
    logic scan_last;
    logic rebase;
    logic launch_next;
  } sts_t;

endpackage
`default_nettype wire

@@ hdl/virtual_time_fair_queue_scheduler_core.sv @@
// Top level of the virtual-time fair queue scheduler.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_data  (func, flow_id, packet_length)
//  out_    | output    | out_valid/out_stall| out_data (send, done, cancel, status)
//  cfg_    | input     | cfg_we             | cfg_addr, cfg_wdata
//
// Release and illegal commands skip the sweep; submit, done and job runs sweep the
// flow time RAM one flow per cycle, adding a length read and launch step when they
// launch a packet, and a done that rebases sweeps it a second time.
// One command is in flight at a time; a new one is taken while the last result waits.
// Synchronous reset clears all flow state; no clearing pass is needed.
`default_nettype none
module virtual_time_fair_queue_scheduler_core #(
  parameter int NUM_FLOWS  = vfq_pkg::NUM_FLOWS_D,
  parameter int TIME_WIDTH = vfq_pkg::TIME_WIDTH_D,
  parameter int LEN_WIDTH  = vfq_pkg::LEN_WIDTH_D
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire vfq_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output vfq_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  vfq_pkg::cmd_t cmd;
  vfq_pkg::sts_t sts;

  vfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  vfq_dp #(
    .NUM_FLOWS  (NUM_FLOWS),
    .TIME_WIDTH (TIME_WIDTH),
    .LEN_WIDTH  (LEN_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire

@@ hdl/vfq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/vfq_ctrl.sv @@
// Sequencer for the scheduler: accept, check, scan, apply, rebase, launch, deliver.
`default_nettype none
module vfq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire vfq_pkg::sts_t sts,
  output vfq_pkg::cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECIDE = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_APPLY  = 8'b0000_1000,
    S_REBASE = 8'b0001_0000,
    S_LREAD  = 8'b0010_0000,
    S_LAUNCH = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.latch    = (state_r == S_IDLE) && in_valid;
    cmd.decide   = (state_r == S_DECIDE);
    cmd.clr_cnt  = (state_r == S_DECIDE) || (state_r == S_APPLY);
    cmd.scan_en  = (state_r == S_SCAN);
    cmd.apply    = (state_r == S_APPLY);
    cmd.reb_en   = (state_r == S_REBASE);
    cmd.launch   = (state_r == S_LAUNCH);
    cmd.load_out = (state_r == S_FIN) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (sts.illegal || sts.is_release) state_nxt = S_FIN;
        else                               state_nxt = S_SCAN;
      end
      S_SCAN:   if (sts.scan_last) state_nxt = S_APPLY;
      S_APPLY: begin
        if (sts.rebase)           state_nxt = S_REBASE;
        else if (sts.launch_next) state_nxt = S_LREAD;
        else                      state_nxt = S_FIN;
      end
      S_REBASE: if (sts.scan_last) state_nxt = S_FIN;
      S_LREAD:  state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_FIN;
      S_FIN:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)    out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/vfq_dp.sv @@
// Datapath: flow tables, scan accumulators, time arithmetic and result register.
`default_nettype none
module vfq_dp #(
  parameter int NUM_FLOWS  = vfq_pkg::NUM_FLOWS_D,
  parameter int TIME_WIDTH = vfq_pkg::TIME_WIDTH_D,
  parameter int LEN_WIDTH  = vfq_pkg::LEN_WIDTH_D
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire vfq_pkg::in_t  in_data,
  output vfq_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic          cfg_addr,
  input  wire logic [31:0]   cfg_wdata,
  input  wire vfq_pkg::cmd_t cmd,
  output vfq_pkg::sts_t      sts
);

  localparam int IW = $clog2(NUM_FLOWS);
  localparam int TW = TIME_WIDTH;
  localparam int LW = LEN_WIDTH;
  localparam int CW = (TW > 32) ? TW : 32;
  localparam logic [IW:0]   NUM_C  = (IW + 1)'(NUM_FLOWS);
  localparam logic [IW-1:0] LAST_I = IW'(NUM_FLOWS - 1);
  localparam logic [CW-1:0] TMASK  = CW'({TW{1'b1}});

  // command latch and configuration
  logic [1:0]    func_r, func_nxt;
  logic [3:0]    fid_r, fid_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [31:0]   max_vt_r, max_vt_nxt;
  logic          cancel_en_r, cancel_en_nxt;

  // scheduler state
  logic [NUM_FLOWS-1:0] waiting_r, waiting_nxt;
  logic                 snd_act_r, snd_act_nxt;
  logic [IW-1:0]        snd_idx_r, snd_idx_nxt;
  logic [LW-1:0]        snd_bytes_r, snd_bytes_nxt;
  logic                 prv_act_r, prv_act_nxt;
  logic [IW-1:0]        prv_idx_r, prv_idx_nxt;
  logic                 job_r, job_nxt;
  logic [NUM_FLOWS-1:0] vld_r, vld_nxt;

  // scan pipeline and accumulators
  logic [IW:0]   cnt_r, cnt_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic [IW-1:0] rd_i_r, rd_i_nxt;
  logic          rvld_r, rvld_nxt;
  logic          have_r, have_nxt;
  logic [TW-1:0] min_v_r, min_v_nxt;
  logic [IW-1:0] min_i_r, min_i_nxt;
  logic [TW-1:0] vt_w_r, vt_w_nxt;
  logic [TW-1:0] vt_s_r, vt_s_nxt;
  logic [TW-1:0] vt_p_r, vt_p_nxt;
  logic [TW-1:0] sub_r, sub_nxt;

  vfq_pkg::out_t res_r, res_nxt;
  vfq_pkg::out_t out_r, out_nxt;

  // RAM ports
  logic          vt_we, len_we;
  logic [IW-1:0] vt_waddr;
  logic [TW-1:0] vt_wdata, vt_q, rd_data;
  logic [LW-1:0] len_q;

  logic [IW-1:0] fidx, widx;
  logic          f_ok, scanning;
  logic [TW-1:0] ct, new_vt, lim, amt, reb_val;
  logic [CW-1:0] max_ext;
  logic          need_reb;

  assign fidx     = IW'(fid_r);
  assign f_ok     = (32'(fid_r) < 32'(NUM_FLOWS));
  assign widx     = (func_r == vfq_pkg::FN_SUBMIT) ? fidx : snd_idx_r;
  assign rd_data  = rvld_r ? vt_q : '0;
  assign scanning = cmd.scan_en || cmd.reb_en;
  assign amt      = TW'(snd_bytes_r);
  assign max_ext  = CW'(max_vt_r);
  assign lim      = (max_ext > TMASK) ? TW'(TMASK) : TW'(max_ext);
  assign need_reb = (vt_w_r > lim) || (amt > lim - vt_w_r);

  // current virtual time from the scan results
  always_comb begin
    if (snd_act_r) begin
      ct = vt_s_r;
    end else begin
      ct = have_r ? min_v_r : '0;
      if (prv_act_r && (!have_r || vt_p_r < min_v_r)) ct = vt_p_r;
    end
  end

  always_comb begin
    if (prv_act_r && prv_idx_r == fidx) new_vt = vt_w_r;
    else                                new_vt = (ct > vt_w_r) ? ct : vt_w_r;
  end

  always_comb begin
    if (rd_i_r == widx)    reb_val = rd_data - sub_r + amt;
    else if (sub_r > rd_data) reb_val = '0;
    else                   reb_val = rd_data - sub_r;
  end

  always_comb begin
    sts             = '0;
    sts.is_release  = (func_r == vfq_pkg::FN_RELEASE);
    sts.scan_last   = rd_v_r && (rd_i_r == LAST_I);
    sts.rebase      = (func_r == vfq_pkg::FN_DONE) && need_reb;
    case (func_r)
      vfq_pkg::FN_SUBMIT:  sts.illegal = !f_ok || waiting_r[fidx] ||
                                         (snd_act_r && snd_idx_r == fidx);
      vfq_pkg::FN_DONE:    sts.illegal = !snd_act_r || job_r;
      vfq_pkg::FN_RELEASE: sts.illegal = !cancel_en_r || !snd_act_r || !f_ok ||
                                         snd_idx_r != fidx || job_r;
      default:             sts.illegal = !job_r || snd_act_r;
    endcase
    case (func_r)
      vfq_pkg::FN_SUBMIT: sts.launch_next = !snd_act_r && !job_r;
      vfq_pkg::FN_JOB:    sts.launch_next = have_r;
      default:            sts.launch_next = 1'b0;
    endcase
  end

  always_comb begin
    func_nxt      = func_r;
    fid_nxt       = fid_r;
    len_nxt       = len_r;
    max_vt_nxt    = max_vt_r;
    cancel_en_nxt = cancel_en_r;
    waiting_nxt   = waiting_r;
    snd_act_nxt   = snd_act_r;
    snd_idx_nxt   = snd_idx_r;
    snd_bytes_nxt = snd_bytes_r;
    prv_act_nxt   = prv_act_r;
    prv_idx_nxt   = prv_idx_r;
    job_nxt       = job_r;
    vld_nxt       = vld_r;
    cnt_nxt       = cnt_r;
    rd_v_nxt      = 1'b0;
    rd_i_nxt      = cnt_r[IW-1:0];
    rvld_nxt      = vld_r[cnt_r[IW-1:0]];
    have_nxt      = have_r;
    min_v_nxt     = min_v_r;
    min_i_nxt     = min_i_r;
    vt_w_nxt      = vt_w_r;
    vt_s_nxt      = vt_s_r;
    vt_p_nxt      = vt_p_r;
    sub_nxt       = sub_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    vt_we         = 1'b0;
    vt_waddr      = widx;
    vt_wdata      = new_vt;
    len_we        = 1'b0;

    if (cfg_we) begin
      if (cfg_addr == vfq_pkg::CFG_MAX_VT) max_vt_nxt    = cfg_wdata;
      else                                 cancel_en_nxt = cfg_wdata[0];
    end

    if (cmd.latch) begin
      func_nxt = in_data.func;
      fid_nxt  = in_data.flow_id;
      len_nxt  = in_data.packet_length[LW-1:0];
      have_nxt = 1'b0;
      res_nxt  = '0;
    end

    if (cmd.decide) begin
      if (sts.illegal) begin
        res_nxt.status = 1'b1;
      end else if (sts.is_release) begin
        snd_act_nxt          = 1'b0;
        job_nxt              = 1'b1;
        res_nxt.cancel_valid = 1'b1;
      end
    end

    if (cmd.clr_cnt) cnt_nxt = '0;

    // issue one read per cycle while the sweep runs
    if (scanning && cnt_r < NUM_C) begin
      rd_v_nxt = 1'b1;
      cnt_nxt  = cnt_r + 1'b1;
    end

    if (cmd.scan_en && rd_v_r) begin
      if (waiting_r[rd_i_r] && (!have_r || rd_data < min_v_r)) begin
        have_nxt  = 1'b1;
        min_v_nxt = rd_data;
        min_i_nxt = rd_i_r;
      end
      if (rd_i_r == widx)      vt_w_nxt = rd_data;
      if (rd_i_r == snd_idx_r) vt_s_nxt = rd_data;
      if (rd_i_r == prv_idx_r) vt_p_nxt = rd_data;
    end

    if (cmd.reb_en && rd_v_r) begin
      vt_we    = 1'b1;
      vt_waddr = rd_i_r;
      vt_wdata = reb_val;
    end

    if (cmd.apply) begin
      case (func_r)
        vfq_pkg::FN_SUBMIT: begin
          vt_we  = 1'b1;
          len_we = 1'b1;
          if (prv_act_r && prv_idx_r == fidx) prv_act_nxt = 1'b0;
          waiting_nxt[fidx] = 1'b1;
          if (!have_r || new_vt < min_v_r || (new_vt == min_v_r && fidx < min_i_r)) begin
            have_nxt  = 1'b1;
            min_v_nxt = new_vt;
            min_i_nxt = fidx;
          end
        end
        vfq_pkg::FN_DONE: begin
          snd_act_nxt        = 1'b0;
          prv_act_nxt        = 1'b1;
          prv_idx_nxt        = snd_idx_r;
          job_nxt            = 1'b1;
          res_nxt.done_valid = 1'b1;
          res_nxt.done_flow  = 4'(snd_idx_r);
          sub_nxt            = have_r ? min_v_r : vt_w_r;
          if (!need_reb) begin
            vt_we    = 1'b1;
            vt_wdata = vt_w_r + amt;
          end
        end
        default: begin
          job_nxt     = 1'b0;
          prv_act_nxt = 1'b0;
        end
      endcase
    end

    if (cmd.launch) begin
      waiting_nxt[min_i_r] = 1'b0;
      snd_act_nxt          = 1'b1;
      snd_idx_nxt          = min_i_r;
      snd_bytes_nxt        = len_q;
      res_nxt.send_valid   = 1'b1;
      res_nxt.send_flow    = 4'(min_i_r);
      res_nxt.send_length  = 16'(len_q);
    end

    if (vt_we) vld_nxt[vt_waddr] = 1'b1;

    if (cmd.load_out) out_nxt = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_vt_r    <= '1;
      cancel_en_r <= 1'b0;
      waiting_r   <= '0;
      snd_act_r   <= 1'b0;
      snd_idx_r   <= '0;
      snd_bytes_r <= '0;
      prv_act_r   <= 1'b0;
      prv_idx_r   <= '0;
      job_r       <= 1'b0;
      vld_r       <= '0;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
    end else begin
      max_vt_r    <= max_vt_nxt;
      cancel_en_r <= cancel_en_nxt;
      waiting_r   <= waiting_nxt;
      snd_act_r   <= snd_act_nxt;
      snd_idx_r   <= snd_idx_nxt;
      snd_bytes_r <= snd_bytes_nxt;
      prv_act_r   <= prv_act_nxt;
      prv_idx_r   <= prv_idx_nxt;
      job_r       <= job_nxt;
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
      rd_v_r      <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    fid_r   <= fid_nxt;
    len_r   <= len_nxt;
    rd_i_r  <= rd_i_nxt;
    rvld_r  <= rvld_nxt;
    have_r  <= have_nxt;
    min_v_r <= min_v_nxt;
    min_i_r <= min_i_nxt;
    vt_w_r  <= vt_w_nxt;
    vt_s_r  <= vt_s_nxt;
    vt_p_r  <= vt_p_nxt;
    sub_r   <= sub_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign out_data = out_r;

  vfq_ram #(.WIDTH(TW), .DEPTH(NUM_FLOWS)) u_vt_ram (
    .clk   (clk),
    .we    (vt_we),
    .waddr (vt_waddr),
    .wdata (vt_wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (vt_q)
  );

  vfq_ram #(.WIDTH(LW), .DEPTH(NUM_FLOWS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (fidx),
    .wdata (len_r),
    .raddr (min_i_r),
    .rdata (len_q)
  );

endmodule
`default_nettype wire

@@ hdl/vfq_checker.sv @@
// Port-level checks for the scheduler core, bound to the top level.
`default_nettype none
module vfq_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire vfq_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while a command is in flight");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.send_valid, out_data.done_valid,
                              out_data.cancel_valid, out_data.status}) <= 1)
    else $error("result reports more than one event");

  a_rej_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.send_flow == 4'd0 &&
                                     out_data.done_flow == 4'd0)
    else $error("rejected command carries a flow");

endmodule

bind virtual_time_fair_queue_scheduler_core vfq_checker u_vfq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
